>>> rtl/core/crce_pkg.sv
// Shared types and constants for the Catmull-Rom cubic evaluator.
// No dependencies; imported by crce_axis_pipe and the top level.
package crce_pkg;

  localparam int COORD_W    = 16;   // signed Q8.8 coordinate
  localparam int PARAM_W    = 18;   // signed Q2.16 curve parameter
  localparam int CLAMP_W    = 17;   // clamped parameter, 0 .. 1.0 unsigned
  localparam int RESULT_W   = 24;   // signed Q16.8 result
  localparam int NUM_AXES   = 3;
  localparam int NUM_STAGES = 6;
  localparam int REG_W      = NUM_AXES * COORD_W;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CLAMP_W-1:0] ONE_Q16 = 17'h10000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_BEFORE = 2'd0,
    CFG_POINT_START  = 2'd1,
    CFG_POINT_END    = 2'd2,
    CFG_POINT_AFTER  = 2'd3
  } crce_cfg_idx_t;

  // One coordinate of the four control points
  typedef struct packed {
    logic signed [COORD_W-1:0] pb;
    logic signed [COORD_W-1:0] ps;
    logic signed [COORD_W-1:0] pe;
    logic signed [COORD_W-1:0] pa;
  } crce_points_t;

  // Per-stage load enables, bit k loads stage k+1
  typedef struct packed {
    logic [NUM_STAGES-1:0] adv;
  } crce_pipe_ctrl_t;

endpackage

>>> rtl/core/crce_axis_pipe.sv
// One coordinate of the evaluator: cubic factors plus the Horner pipelines
// for position and velocity, stages two to six. Depends on crce_pkg.
module crce_axis_pipe import crce_pkg::*; (
  input  logic                        clk,
  input  crce_pipe_ctrl_t             ctrl,
  input  crce_points_t                pts,
  input  logic signed [PARAM_W-1:0]   t_s1,
  input  logic        [CLAMP_W-1:0]   tc_s1,
  output logic signed [RESULT_W-1:0]  pos,
  output logic signed [RESULT_W-1:0]  vel
);

  // Doubled cubic factors, units of 2^-9
  logic signed [18:0] a0_c, a0;
  logic signed [19:0] a1_c, a1;
  logic signed [16:0] a2_c, a2;
  logic signed [16:0] a3_c, a3;

  always_comb begin
    a0_c = 19'sd3 * (19'(pts.ps) - 19'(pts.pe)) + (19'(pts.pa) - 19'(pts.pb));
    a1_c = 20'sd4 * 20'(pts.pe) - 20'sd5 * 20'(pts.ps) - 20'(pts.pa)
         + 20'sd2 * 20'(pts.pb);
    a2_c = 17'(pts.pe) - 17'(pts.pb);
    a3_c = 17'(pts.ps) <<< 1;
  end

  // Factors are registered from the control point registers
  always_ff @(posedge clk) begin
    a0 <= a0_c;
    a1 <= a1_c;
    a2 <= a2_c;
    a3 <= a3_c;
  end

  // Stage 2: first Horner step for both chains
  logic signed [CLAMP_W:0]  tcs1;
  logic signed [20:0]       a0x3;
  logic signed [36:0]       m_h1, h1_c;
  logic signed [38:0]       m_g1, g1_c;
  logic signed [36:0]       h1;
  logic signed [38:0]       g1;
  logic signed [PARAM_W-1:0] t2;
  logic        [CLAMP_W-1:0] tc2;

  always_comb begin
    tcs1 = signed'({1'b0, tc_s1});
    a0x3 = 21'(a0) * 21'sd3;
    m_h1 = a0 * tcs1;
    h1_c = m_h1 + (37'(a1) <<< 16);
    m_g1 = a0x3 * t_s1;
    g1_c = m_g1 + (39'(a1) <<< 17);
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[1]) begin
      h1  <= h1_c;
      g1  <= g1_c;
      t2  <= t_s1;
      tc2 <= tc_s1;
    end
  end

  // Stage 3: second multiply, split into high and low partial products
  logic signed [CLAMP_W:0] tcs2;
  logic signed [20:0]      h1_hi;
  logic signed [16:0]      h1_lo;
  logic signed [22:0]      g1_hi;
  logic signed [16:0]      g1_lo;
  logic signed [37:0]      ph_hi_c, ph_hi;
  logic signed [33:0]      ph_lo_c, ph_lo;
  logic signed [40:0]      pv_hi_c, pv_hi;
  logic signed [34:0]      pv_lo_c, pv_lo;
  logic        [CLAMP_W-1:0] tc3;

  always_comb begin
    tcs2    = signed'({1'b0, tc2});
    h1_hi   = signed'(h1[36:16]);
    h1_lo   = signed'({1'b0, h1[15:0]});
    g1_hi   = signed'(g1[38:16]);
    g1_lo   = signed'({1'b0, g1[15:0]});
    ph_hi_c = h1_hi * tcs2;
    ph_lo_c = h1_lo * tcs2;
    pv_hi_c = g1_hi * t2;
    pv_lo_c = g1_lo * t2;
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[2]) begin
      ph_hi <= ph_hi_c;
      ph_lo <= ph_lo_c;
      pv_hi <= pv_hi_c;
      pv_lo <= pv_lo_c;
      tc3   <= tc2;
    end
  end

  // Stage 4: recombine; velocity is finished here with round to nearest
  logic signed [53:0] h2_c, h2;
  logic signed [56:0] v_sum;
  logic signed [RESULT_W-1:0] vel4, vel5;
  logic        [CLAMP_W-1:0] tc4;

  always_comb begin
    h2_c  = (54'(ph_hi) <<< 16) + 54'(ph_lo) + (54'(a2) <<< 32);
    v_sum = (57'(pv_hi) <<< 16) + 57'(pv_lo) + (57'(a2) <<< 32) + (57'sd1 <<< 32);
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[3]) begin
      h2   <= h2_c;
      vel4 <= signed'(v_sum[56:33]);
      tc4  <= tc3;
    end
  end

  // Stage 5: third position multiply, split at bit 32
  logic signed [CLAMP_W:0] tcs4;
  logic signed [21:0]      h2_hi;
  logic signed [32:0]      h2_lo;
  logic signed [39:0]      q_hi_c, q_hi;
  logic signed [50:0]      q_lo_c, q_lo;

  always_comb begin
    tcs4   = signed'({1'b0, tc4});
    h2_hi  = signed'(h2[53:32]);
    h2_lo  = signed'({1'b0, h2[31:0]});
    q_hi_c = h2_hi * tcs4;
    q_lo_c = h2_lo * tcs4;
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[4]) begin
      q_hi <= q_hi_c;
      q_lo <= q_lo_c;
      vel5 <= vel4;
    end
  end

  // Stage 6: final position sum, round to nearest, output register
  logic signed [72:0] p_sum;

  always_comb begin
    p_sum = (73'(q_hi) <<< 32) + 73'(q_lo) + (73'(a3) <<< 48) + (73'sd1 <<< 48);
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[5]) begin
      pos <= signed'(p_sum[72:49]);
      vel <= vel5;
    end
  end

endmodule

>>> rtl/core/catmull_rom_cubic_evaluator_unit.sv
// Top level of the Catmull-Rom cubic evaluator: configuration registers,
// input stage, valid/flow control and three coordinate pipelines.
// Depends on crce_pkg and crce_axis_pipe.

// Evaluates one Catmull-Rom segment set by four control points written
// through the configuration port. Each stream transaction carries a
// parameter t (signed Q2.16); the block returns the position at t clamped
// to [0,1] and the derivative at the raw t, all three axes, as signed Q16.8
// rounded to nearest. Throughput is one transaction per cycle while the
// output is not stalled; the position path has six register stages (input
// register, three multiply stages, two summing stages). Control points
// take effect after passing the point registers and then the factor
// registers. A stall on the output side is absorbed stage by stage, so empty
// stages keep taking input while a result waits.
module catmull_rom_cubic_evaluator_unit import crce_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]      cfg_data,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,   // curve_param[17:0], zero pad
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [143:0]          m_axis_tdata    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
);

  // Control point registers
  logic [REG_W-1:0] point_before, point_start, point_end, point_after;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_before <= '0;
      point_start  <= '0;
      point_end    <= '0;
      point_after  <= '0;
    end else if (cfg_we) begin
      case (crce_cfg_idx_t'(cfg_index))
        CFG_POINT_BEFORE: point_before <= cfg_data;
        CFG_POINT_START:  point_start  <= cfg_data;
        CFG_POINT_END:    point_end    <= cfg_data;
        CFG_POINT_AFTER:  point_after  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flow control: a stage loads when empty or when its successor loads
  logic [NUM_STAGES-1:0] valid;
  crce_pipe_ctrl_t       ctrl;

  always_comb begin
    ctrl.adv[NUM_STAGES-1] = !valid[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ctrl.adv[k] = !valid[k] || ctrl.adv[k+1];
    end
  end

  assign s_axis_tready = ctrl.adv[0] && !rst;
  assign m_axis_tvalid = valid[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctrl.adv[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ctrl.adv[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // Stage 1: input register with clamp to [0,1]
  logic signed [PARAM_W-1:0] t_in, t_s1;
  logic        [CLAMP_W-1:0] tc_in, tc_s1;

  always_comb begin
    t_in = signed'(s_axis_tdata[PARAM_W-1:0]);
    if (t_in < 0) begin
      tc_in = '0;
    end else if (t_in > signed'({1'b0, ONE_Q16})) begin
      tc_in = ONE_Q16;
    end else begin
      tc_in = t_in[CLAMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[0]) begin
      t_s1  <= t_in;
      tc_s1 <= tc_in;
    end
  end

  // Per-axis pipelines
  logic signed [RESULT_W-1:0] pos [NUM_AXES];
  logic signed [RESULT_W-1:0] vel [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    crce_points_t pts;

    assign pts.pb = point_before[a*COORD_W +: COORD_W];
    assign pts.ps = point_start [a*COORD_W +: COORD_W];
    assign pts.pe = point_end   [a*COORD_W +: COORD_W];
    assign pts.pa = point_after [a*COORD_W +: COORD_W];

    crce_axis_pipe u_axis (
      .clk   (clk),
      .ctrl  (ctrl),
      .pts   (pts),
      .t_s1  (t_s1),
      .tc_s1 (tc_s1),
      .pos   (pos[a]),
      .vel   (vel[a])
    );
  end

  assign m_axis_tdata = {vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]};

`ifndef SYNTH
  // Occupancy grows by at most one transaction per cycle
  a_occupancy_step: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) <= $countones($past(valid)) + 1)
    else $error("pipeline occupancy grew by more than one");

  // Input back-pressure only when the output holds a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    (!s_axis_tready && !rst) |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without an output stall");

  // Reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && valid == '0))
    else $error("pipeline not empty after reset");
`endif

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for catmull_rom_cubic_evaluator_unit.
// Depends on crce_pkg and the evaluator RTL. Each result is predicted with
// exact wide integer arithmetic and checked field by field on the output stream.
module tb;
  import crce_pkg::*;

  typedef logic signed [127:0] wide_t;
  localparam wide_t T_ONE    = 65536;
  localparam int    RES_BITS = 6 * RESULT_W;
  localparam int    PAD_W    = 24 - PARAM_W;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 cfg_we        = 1'b0;
  crce_cfg_idx_t        cfg_index     = CFG_POINT_BEFORE;
  logic [REG_W-1:0]     cfg_data      = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata  = '0;   // curve_param[17:0], zero pad
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [RES_BITS-1:0]  m_axis_tdata;         // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z

  // Mirror of the control points, pending parameters and predicted samples
  logic [REG_W-1:0]          ctrl_pts [4] = '{default: '0};
  logic signed [PARAM_W-1:0] param_q [$];
  logic [RES_BITS-1:0]       sample_q [$];
  bit                        idle_on      = 1'b0;
  int                        send_gap     = 0;
  int                        recv_gap     = 0;
  int                        results_seen = 0;
  int                        fail_count   = 0;
  string field_name [6] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};

  catmull_rom_cubic_evaluator_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  // Position and velocity of the segment for one parameter value, all axes.
  // Factors are held doubled (units of 2^-9); everything is exact until the
  // final round to nearest, ties upwards.
  function automatic logic [RES_BITS-1:0] eval_segment(input logic signed [PARAM_W-1:0] t);
    wide_t tw, tc, pb, ps, pe, pa, f0, f1, f2, f3, pos, vel;
    logic [RES_BITS-1:0] res;
    tw = t;
    tc = (tw < 0) ? 0 : ((tw > T_ONE) ? T_ONE : tw);
    for (int k = 0; k < NUM_AXES; k++) begin
      pb = $signed(ctrl_pts[CFG_POINT_BEFORE][COORD_W*k +: COORD_W]);
      ps = $signed(ctrl_pts[CFG_POINT_START][COORD_W*k +: COORD_W]);
      pe = $signed(ctrl_pts[CFG_POINT_END][COORD_W*k +: COORD_W]);
      pa = $signed(ctrl_pts[CFG_POINT_AFTER][COORD_W*k +: COORD_W]);
      f0 = 3 * (ps - pe) + (pa - pb);
      f1 = 4 * pe - 5 * ps - pa + 2 * pb;
      f2 = pe - pb;
      f3 = 2 * ps;
      // position at clamped t, value / 2^57 in Q8.8 units
      pos = f0 * tc * tc * tc + ((f1 * tc * tc) <<< 16) + ((f2 * tc) <<< 32) + (f3 <<< 48);
      pos = (pos + (wide_t'(1) <<< 48)) >>> 49;
      // velocity at raw t, value / 2^41 in Q8.8 units
      vel = 3 * f0 * tw * tw + ((2 * f1 * tw) <<< 16) + (f2 <<< 32);
      vel = (vel + (wide_t'(1) <<< 32)) >>> 33;
      res[RESULT_W*k +: RESULT_W]            = pos[RESULT_W-1:0];
      res[RESULT_W*(k+NUM_AXES) +: RESULT_W] = vel[RESULT_W-1:0];
    end
    return res;
  endfunction

  // Parameter mix: mostly inside [0,1], plus clamp regions and boundaries
  function automatic logic signed [PARAM_W-1:0] draw_param();
    case ($urandom_range(0, 9))
      0: return PARAM_W'($urandom_range(0, 262143));
      1: return PARAM_W'($urandom_range(131072, 262143));   // negative
      2: return PARAM_W'($urandom_range(65537, 131071));    // above one
      3: case ($urandom_range(0, 5))
           0: return 0;
           1: return 1;
           2: return 65535;
           3: return 65536;
           4: return 65537;
           default: return -1;
         endcase
      default: return PARAM_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] draw_coord();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return COORD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Register write, only issued while the pipeline is empty
  task automatic write_point(input crce_cfg_idx_t idx, input logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    ctrl_pts[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_points(input logic [REG_W-1:0] b, s, e, a);
    write_point(CFG_POINT_BEFORE, b);
    write_point(CFG_POINT_START, s);
    write_point(CFG_POINT_END, e);
    write_point(CFG_POINT_AFTER, a);
  endtask

  // Wait for the sender to run dry and every predicted sample to arrive
  task automatic drain();
    do @(negedge clk);
    while (param_q.size() != 0 || s_axis_tvalid || sample_q.size() != 0);
    repeat (NUM_STAGES + 4) @(posedge clk);
  endtask

  // Sender: one parameter per transaction, random gap drawn per item while idle_on is set
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        sample_q.push_back(eval_segment(s_axis_tdata[PARAM_W-1:0]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (param_q.size() > 0) begin
          s_axis_tdata  <= {{PAD_W{1'b0}}, param_q.pop_front()};
          s_axis_tvalid <= 1'b1;
          send_gap = idle_on ? $urandom_range(0, 4) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transaction; one long hold-off fills the pipe
  always @(posedge clk) begin : result_check
    logic [RES_BITS-1:0] want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (sample_q.size() == 0) begin
          $error("unexpected result transaction %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = sample_q.pop_front();
          for (int k = 0; k < 6; k++)
            if (m_axis_tdata[RESULT_W*k +: RESULT_W] !== want[RESULT_W*k +: RESULT_W]) begin
              $error("%s mismatch: expected %h, got %h", field_name[k],
                     want[RESULT_W*k +: RESULT_W], m_axis_tdata[RESULT_W*k +: RESULT_W]);
              fail_count++;
            end
        end
        results_seen++;
        if (results_seen == 500) recv_gap = 200;
        else recv_gap = idle_on ? $urandom_range(0, 4) : 0;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus: directed parameters first, then random runs over several point sets
  initial begin
    logic signed [PARAM_W-1:0] directed [13] = '{
      18'sh20000, 18'sh1FFFF, 18'sh00000, 18'sh00001, 18'sh3FFFF, 18'sh0FFFF,
      18'sh10000, 18'sh10001, 18'sh08000, 18'sh15555, 18'sh2AAAA, 18'sh18000,
      18'sh30000};
    logic [REG_W-1:0] pts [4];
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset values of the points
    @(negedge clk);
    param_q.push_back(0);
    param_q.push_back(65536);
    drain();

    // ordinary segment, extremes of t and the clamp boundaries
    set_points(48'h0100_FF00_0080, 48'h0200_0040_FF80, 48'hFE00_0300_0140, 48'h00C0_FD80_0500);
    idle_on = 1'b1;
    @(negedge clk);
    foreach (directed[i]) param_q.push_back(directed[i]);
    drain();

    // extreme point sets, then random ones
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: pts = '{48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF};
        1: pts = '{48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000};
        2: pts = '{48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF};
        3: pts = '{48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000};
        default:
          foreach (pts[i]) pts[i] = {draw_coord(), draw_coord(), draw_coord()};
      endcase
      set_points(pts[0], pts[1], pts[2], pts[3]);
      idle_on = (ph % 3) != 0;
      @(negedge clk);
      repeat (170) param_q.push_back(draw_param());
      drain();
    end

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
